/* hdl/assert_macros.svh */
// Assertion macros for the range minimum tree RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RMT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RMT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define RMT_ASSERT(lbl, clk, rst_n, prop, msg)
`define RMT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

/* hdl/rmt_pkg.sv */
// Package with constants, types and helpers of the range minimum tree.
`timescale 1ns / 1ps
package rmt_pkg;

	localparam int LEAF_COUNT = 1024;
	localparam int ROW_W      = $clog2(LEAF_COUNT);
	localparam int NODE_W     = $clog2(2 * LEAF_COUNT + 1);
	localparam int IDX_W      = 20;
	localparam int VAL_W      = 32;
	localparam int ROW_DATA_W = 2 * VAL_W;

	localparam logic signed [VAL_W-1:0] LARGEST = 32'sh7FFF_FFFF;

	typedef enum logic {
		OP_UPDATE = 1'b0,
		OP_QUERY  = 1'b1
	} rmt_op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_QRY_RD,
		ST_QRY_ACC,
		ST_DONE
	} rmt_state_t;

	typedef struct packed {
		rmt_op_t                  opcode;
		logic [9:0]               first_index;
		logic [10:0]              end_index;
		logic signed [VAL_W-1:0]  new_value;
	} rmt_item_t;

	typedef struct packed {
		logic                     valid;
		logic signed [VAL_W-1:0]  value;
	} rmt_result_t;

	function automatic logic signed [VAL_W-1:0] rmt_min(
		input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b
	);
		return (a < b) ? a : b;
	endfunction

endpackage

/* hdl/rmt_node_ram.sv */
// Node store RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
module rmt_node_ram #(
	parameter int ADDR_W = 10,
	parameter int DATA_W = 64
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re_a,
	input  logic [ADDR_W-1:0] raddr_a,
	output logic [DATA_W-1:0] rdata_a,
	input  logic              re_b,
	input  logic [ADDR_W-1:0] raddr_b,
	output logic [DATA_W-1:0] rdata_b
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re_a) begin
			rdata_a <= mem[raddr_a];
		end
	end

	always_ff @(posedge clk) begin
		if (re_b) begin
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

/* hdl/rmt_walker.sv */
// Tree walker: clearing pass, point update and range query over the node RAM.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rmt_walker
	import rmt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_accept,
	input  rmt_item_t   item,
	output logic        idle,
	output rmt_result_t res,
	input  logic        res_taken
);

	rmt_state_t state_q, state_d;

	logic [NODE_W-1:0]       node_q;
	logic [NODE_W-1:0]       hi_q;
	logic signed [VAL_W-1:0] cur_q;
	logic signed [VAL_W-1:0] best_q;
	logic [ROW_W-1:0]        clr_q;

	logic                    we;
	logic [ROW_W-1:0]        waddr;
	logic [ROW_DATA_W-1:0]   wdata;
	logic                    re_a;
	logic                    re_b;
	logic [ROW_W-1:0]        raddr_a;
	logic [ROW_W-1:0]        raddr_b;
	logic [ROW_DATA_W-1:0]   rdata_a;
	logic [ROW_DATA_W-1:0]   rdata_b;

	logic [IDX_W-1:0]        first_x;
	logic [IDX_W-1:0]        end_x;
	logic [IDX_W-1:0]        hi_clamp;
	logic                    upd_ok;
	logic                    qry_empty;
	logic                    walk_on;
	logic                    clr_last;
	logic                    upd_top;
	logic [ROW_DATA_W-1:0]   upd_row;
	logic signed [VAL_W-1:0] lo_val;
	logic signed [VAL_W-1:0] hi_val;

	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(LEAF_COUNT - 1);

	assign first_x   = IDX_W'(item.first_index);
	assign end_x     = IDX_W'(item.end_index);
	assign hi_clamp  = (end_x > IDX_W'(LEAF_COUNT)) ? IDX_W'(LEAF_COUNT) : end_x;
	assign upd_ok    = first_x < IDX_W'(LEAF_COUNT);
	assign qry_empty = first_x >= hi_clamp;
	assign walk_on   = node_q < hi_q;
	assign clr_last  = clr_q == LAST_ROW;
	assign upd_top   = (node_q >> 1) == '0;

	assign upd_row = node_q[0] ? {cur_q, rdata_a[VAL_W-1:0]}
	                           : {rdata_a[ROW_DATA_W-1:VAL_W], cur_q};
	assign lo_val  = node_q[0] ? $signed(rdata_a[ROW_DATA_W-1:VAL_W]) : LARGEST;
	assign hi_val  = hi_q[0] ? $signed(rdata_b[VAL_W-1:0]) : LARGEST;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_accept) begin
					if (item.opcode == OP_UPDATE) begin
						state_d = upd_ok ? ST_UPD_RD : ST_IDLE;
					end else begin
						state_d = qry_empty ? ST_DONE : ST_QRY_RD;
					end
				end
			end
			ST_UPD_RD:  state_d = ST_UPD_WR;
			ST_UPD_WR:  state_d = upd_top ? ST_IDLE : ST_UPD_RD;
			ST_QRY_RD:  state_d = walk_on ? ST_QRY_ACC : ST_DONE;
			ST_QRY_ACC: state_d = ST_QRY_RD;
			ST_DONE: begin
				if (res_taken) begin
					state_d = ST_IDLE;
				end
			end
			default:    state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		idle      = 1'b0;
		we        = 1'b0;
		waddr     = ROW_W'(node_q >> 1);
		wdata     = upd_row;
		re_a      = 1'b0;
		re_b      = 1'b0;
		raddr_a   = ROW_W'(node_q >> 1);
		raddr_b   = ROW_W'((hi_q - NODE_W'(1)) >> 1);
		res.valid = 1'b0;
		res.value = best_q;
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = {LARGEST, LARGEST};
			end
			ST_IDLE:    idle = 1'b1;
			ST_UPD_RD:  re_a = 1'b1;
			ST_UPD_WR:  we = 1'b1;
			ST_QRY_RD: begin
				re_a = walk_on;
				re_b = walk_on;
			end
			ST_QRY_ACC: ;
			ST_DONE:    res.valid = 1'b1;
			default:    ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ROW_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				node_q <= NODE_W'(first_x + IDX_W'(LEAF_COUNT));
				hi_q   <= NODE_W'(hi_clamp + IDX_W'(LEAF_COUNT));
				cur_q  <= item.new_value;
				best_q <= LARGEST;
			end
			ST_UPD_WR: begin
				cur_q  <= rmt_min($signed(upd_row[ROW_DATA_W-1:VAL_W]),
				                  $signed(upd_row[VAL_W-1:0]));
				node_q <= node_q >> 1;
			end
			ST_QRY_ACC: begin
				best_q <= rmt_min(best_q, rmt_min(lo_val, hi_val));
				node_q <= (node_q + NODE_W'(node_q[0])) >> 1;
				hi_q   <= (hi_q - NODE_W'(hi_q[0])) >> 1;
			end
			default: ;
		endcase
	end

	rmt_node_ram #(
		.ADDR_W(ROW_W),
		.DATA_W(ROW_DATA_W)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.re_a   (re_a),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a),
		.re_b   (re_b),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

	`RMT_ASSERT(a_upd_node, clk, arst_n, (state_q == ST_UPD_WR) |-> (node_q != '0), "update walk past root")
	`RMT_ASSERT(a_qry_order, clk, arst_n, (state_q == ST_QRY_RD || state_q == ST_QRY_ACC) |-> (node_q <= hi_q), "query bounds crossed")
	`RMT_ASSERT(a_clear_done, clk, arst_n, (state_q == ST_IDLE && $past(state_q) == ST_CLEAR) |-> ($past(clr_q) == LAST_ROW), "clearing pass cut short")
	`RMT_ASSERT_NEXT(a_done_hold, clk, arst_n, (state_q == ST_DONE && !res_taken), (state_q == ST_DONE && $stable(best_q)), "result dropped before hand-off")

endmodule

/* hdl/range_minimum_tree_top.sv */
// Range minimum segment tree: top level with input handshake and result register.
// Update: each tree level, leaf to root, takes a read state (ST_UPD_RD) then a write state (ST_UPD_WR).
// Query: each level walked takes a read state (ST_QRY_RD) then an accumulate state (ST_QRY_ACC);
// the result waits in ST_DONE until the result register takes it. in_ready is high only when idle,
// so no item is accepted before the last is through. Reset: a clearing pass fills all LEAF_COUNT = 1024
// rows of the node RAM with the largest signed value; in_ready stays low until it ends.
`timescale 1ns / 1ps
module range_minimum_tree_top
	import rmt_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    opcode,
	input  logic [9:0]              first_index,
	input  logic [10:0]             end_index,
	input  logic signed [VAL_W-1:0] new_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [VAL_W-1:0] min_value
);

	rmt_item_t               item;
	rmt_result_t             res;
	logic                    idle;
	logic                    res_taken;
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] min_value_q;

	assign item.opcode      = rmt_op_t'(opcode);
	assign item.first_index = first_index;
	assign item.end_index   = end_index;
	assign item.new_value   = new_value;

	assign in_ready  = idle;
	assign res_taken = res.valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign min_value = min_value_q;

	rmt_walker u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_accept(in_valid && in_ready),
		.item       (item),
		.idle       (idle),
		.res        (res),
		.res_taken  (res_taken)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_taken) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_taken) begin
			min_value_q <= res.value;
		end
	end

endmodule
